// File: rtl/cte_pkg.sv
package cte_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned EpochW  = 38;

  // Day count since 1970 stays below 2^23 for any 14-bit year.
  localparam int unsigned DaysW    = 23;
  localparam int unsigned MDaysW   = 9;
  localparam int unsigned LeapsW   = 12;
  localparam int unsigned TodW     = 17;
  localparam int unsigned DaySecW  = 40;
  localparam int unsigned TotalW   = 41;
  localparam int unsigned Q4W      = YearW - 2;
  // floor(n / 100) == (n * 5243) >> 19 for every n below 2^14
  localparam int unsigned Recip100W     = 13;
  localparam int unsigned Recip100Shift = 19;
  localparam int unsigned ProdW         = YearW + Recip100W;
  localparam int unsigned Q100W         = ProdW - Recip100Shift;

  localparam logic [YearW-1:0]     EpochYear        = 14'd1970;
  localparam logic [LeapsW-1:0]    LeapsBeforeEpoch = 12'd477;
  localparam logic [Recip100W-1:0] Recip100         = 13'd5243;
  localparam logic [MonthW-1:0]    MonthJan         = 4'd1;
  localparam logic [MonthW-1:0]    MonthFeb         = 4'd2;
  localparam logic [MonthW-1:0]    MonthDec         = 4'd12;
  localparam logic [16:0]          SecsPerDay       = 17'd86400;
  localparam logic [11:0]          SecsPerHour      = 12'd3600;
  localparam logic [5:0]           SecsPerMinute    = 6'd60;
  localparam logic [8:0]           DaysPerYear      = 9'd365;
  localparam logic [6:0]           Hundred          = 7'd100;

  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } in_t;

  typedef struct packed {
    logic [EpochW-1:0] epoch_seconds;
    logic              invalid;
  } out_t;

  // Classified item handed from the front stage to the arithmetic back end.
  typedef struct packed {
    logic               invalid;
    logic [YearW-1:0]   year;
    logic [YearW-1:0]   year_off;
    logic [Q4W-1:0]     q4_prev;
    logic [ProdW-1:0]   prod_prev;
    logic [ProdW-1:0]   prod_year;
    logic [MDaysW-1:0]  mdays;
    logic               after_feb;
    logic [DayW-1:0]    day_m1;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } item_t;

  // Days in the year before the first of the given month (non-leap year).
  function automatic logic [MDaysW-1:0] month_days(input logic [MonthW-1:0] m);
    logic [MDaysW-1:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/cte_front.sv
module cte_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  cte_pkg::in_t  in_i,
  output logic          q_push_o,
  input  logic          q_full_i,
  output cte_pkg::item_t item_o
);
  import cte_pkg::*;

  logic             valid_q, valid_d;
  item_t            item_q, item_d;
  logic             accept;
  logic [YearW-1:0] year_prev;

  assign q_push_o = valid_q && !q_full_i;
  assign full     = valid_q && q_full_i;
  assign accept   = push && !full;
  assign item_o   = item_q;

  assign year_prev = in_i.year - YearW'(1);

  always_comb begin
    item_d           = item_q;
    item_d.invalid   = (in_i.year < EpochYear) || (in_i.month < MonthJan) ||
                       (in_i.month > MonthDec) || (in_i.day == '0);
    item_d.year      = in_i.year;
    item_d.year_off  = in_i.year - EpochYear;
    item_d.q4_prev   = year_prev[YearW-1:2];
    item_d.prod_prev = ProdW'(year_prev) * ProdW'(Recip100);
    item_d.prod_year = ProdW'(in_i.year) * ProdW'(Recip100);
    item_d.mdays     = month_days(in_i.month);
    item_d.after_feb = in_i.month > MonthFeb;
    item_d.day_m1    = in_i.day - DayW'(1);
    item_d.hour      = in_i.hour;
    item_d.minute    = in_i.minute;
    item_d.second    = in_i.second;
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// File: rtl/cte_fifo.sv
module cte_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cte_pkg::item_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output cte_pkg::item_t data_o
);
  import cte_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/cte_back.sv
module cte_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  cte_pkg::item_t item_i,
  output logic           q_pop_o,
  output logic           empty,
  input  logic           pop,
  output cte_pkg::out_t  res_o
);
  import cte_pkg::*;

  // Stage 1: leap counts and year days
  logic               s1_valid_q;
  logic               s1_inv_q;
  logic [DaysW-1:0]   s1_ydays_q;
  logic [LeapsW-1:0]  s1_leaps_q;
  logic               s1_leap_add_q;
  logic [MDaysW-1:0]  s1_mdays_q;
  logic [DayW-1:0]    s1_day_m1_q;
  logic [HourW-1:0]   s1_hour_q;
  logic [MinuteW-1:0] s1_minute_q;
  logic [SecondW-1:0] s1_second_q;
  // Stage 2: day count and time of day
  logic               s2_valid_q;
  logic               s2_inv_q;
  logic [DaysW-1:0]   s2_days_q;
  logic [TodW-1:0]    s2_tod_q;
  // Stage 3: day seconds
  logic               s3_valid_q;
  logic               s3_inv_q;
  logic [DaySecW-1:0] s3_dsec_q;
  logic [TodW-1:0]    s3_tod_q;
  // Output register
  logic               out_valid_q;
  out_t               res_q, res_d;

  logic               adv;
  logic [Q100W-1:0]   q100_prev, q100_year;
  logic [Q100W-3:0]   q400_prev;
  logic [LeapsW-1:0]  leaps_d;
  logic               cent_year, leap_year;
  logic [DaysW-1:0]   days_d;
  logic [TodW-1:0]    tod_d;
  logic [DaySecW-1:0] dsec_d;
  logic [TotalW-1:0]  total;

  // Whole back end moves together; it stalls only while a result waits unread.
  assign adv     = !out_valid_q || pop;
  assign q_pop_o = adv && !q_empty_i;
  assign empty   = !out_valid_q;
  assign res_o   = res_q;

  assign q100_prev = item_i.prod_prev[ProdW-1:Recip100Shift];
  assign q400_prev = q100_prev[Q100W-1:2];
  assign q100_year = item_i.prod_year[ProdW-1:Recip100Shift];
  assign leaps_d   = LeapsW'(item_i.q4_prev) - LeapsW'(q100_prev) + LeapsW'(q400_prev)
                     - LeapsBeforeEpoch;
  assign cent_year = {1'b0, item_i.year} == (15'(q100_year) * 15'(Hundred));
  assign leap_year = (item_i.year[1:0] == 2'b00 && !cent_year) ||
                     (cent_year && q100_year[1:0] == 2'b00);

  assign days_d = s1_ydays_q + DaysW'(s1_leaps_q) + DaysW'(s1_mdays_q)
                  + DaysW'(s1_leap_add_q) + DaysW'(s1_day_m1_q);
  assign tod_d  = TodW'(s1_hour_q) * TodW'(SecsPerHour)
                  + TodW'(s1_minute_q) * TodW'(SecsPerMinute) + TodW'(s1_second_q);
  assign dsec_d = DaySecW'(s2_days_q) * DaySecW'(SecsPerDay);
  assign total  = TotalW'(s3_dsec_q) + TotalW'(s3_tod_q);

  always_comb begin
    res_d.invalid = s3_inv_q;
    if (s3_inv_q) begin
      res_d.epoch_seconds = '0;
    end else if (total[TotalW-1:EpochW] != '0) begin
      res_d.epoch_seconds = '1;
    end else begin
      res_d.epoch_seconds = total[EpochW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= !q_empty_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_inv_q      <= item_i.invalid;
      s1_ydays_q    <= DaysW'(item_i.year_off) * DaysW'(DaysPerYear);
      s1_leaps_q    <= leaps_d;
      s1_leap_add_q <= item_i.after_feb && leap_year;
      s1_mdays_q    <= item_i.mdays;
      s1_day_m1_q   <= item_i.day_m1;
      s1_hour_q     <= item_i.hour;
      s1_minute_q   <= item_i.minute;
      s1_second_q   <= item_i.second;
      s2_inv_q      <= s1_inv_q;
      s2_days_q     <= days_d;
      s2_tod_q      <= tod_d;
      s3_inv_q      <= s2_inv_q;
      s3_dsec_q     <= dsec_d;
      s3_tod_q      <= s2_tod_q;
      res_q         <= res_d;
    end
  end

endmodule

// File: rtl/calendar_to_epoch_seconds_unit.sv
// Gregorian date and time to seconds since 1970-01-01 00:00:00.
//
// Input side is a queue write port: a transaction happens on a clock edge with
// push high and full low; in_i carries year, month, day, hour, minute, second.
// Result side is a queue read port: while empty is low res_o shows the oldest
// result, and a transaction happens on an edge with pop high and empty low.
// epoch_seconds is zero and invalid is set for a year before 1970, a month
// outside 1..12 or day zero; counts past 2^38-1 saturate.
// One transaction per cycle is sustained when pop is held high. A front
// register classifies the date and runs the divide-by-100 reciprocal products,
// a QueueDepth-entry queue decouples it from a three-stage arithmetic back
// end ending in an output register. When the reader stalls, the back end
// holds and the front keeps taking transactions until the queue and front
// register fill, then full rises. Reset empties every stage; no setup is
// needed afterwards.
module calendar_to_epoch_seconds_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  cte_pkg::in_t  in_i,
  output logic          empty,
  input  logic          pop,
  output cte_pkg::out_t res_o
);
  import cte_pkg::*;

  logic  q_push, q_full, q_pop, q_empty;
  item_t front_item, back_item;

  cte_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .in_i     (in_i),
    .q_push_o (q_push),
    .q_full_i (q_full),
    .item_o   (front_item)
  );

  cte_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (back_item)
  );

  cte_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .item_i    (back_item),
    .q_pop_o   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .res_o     (res_o)
  );

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.invalid) |-> (res_o.epoch_seconds == '0))
    else $error("invalid result carries nonzero seconds");

  a_full_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without an input transaction");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_o)))
    else $error("waiting result changed or vanished");

endmodule
